// ----- rtl/core/box_mean_filter_2d_unit_macros.svh -----
// Assertion macros for the box mean filter block.
`ifndef BOX_MEAN_FILTER_2D_UNIT_MACROS_SVH
`define BOX_MEAN_FILTER_2D_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst is high.
`define BMF2D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box mean filter: assertion failed");
// Next-cycle implication.
`define BMF2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box mean filter: assertion failed");
`else
`define BMF2D_ASSERT_IMPL(lbl, ante, cons)
`define BMF2D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/bmf2d_pkg.sv -----
// Shared types and constants of the box mean filter.
package bmf2d_pkg;

  localparam int COL_DEPTH = 15;  // column sums kept for the widest window

  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mean_value;
    logic       last_of_run;
    logic       end_of_frame;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_SHIFT,
    S_DIV,
    S_PUSH,
    S_STEP
  } state_t;

  typedef struct packed {
    logic load;      // take input item
    logic rd_issue;  // read one line store row
    logic rd_acc;    // add the read sample to the column sum
    logic wr;        // store the new sample
    logic shift;     // shift a column sum into the window
    logic div_step;  // one quotient bit
    logic push;      // load the output register
    logic tail_inc;  // next right-edge zero column
    logic advance;   // step raster position
  } cmd_t;

  typedef struct packed {
    logic rd_go;
    logic emit_now;
    logic div_last;
    logic out_free;
    logic tail_more;
  } status_t;

endpackage

// ----- rtl/core/bmf2d_ctrl.sv -----
// Sequencer of the box mean filter.
module bmf2d_ctrl import bmf2d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (st.rd_go) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_ACC;
        end else begin
          cmd.wr     = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_ACC: begin
        cmd.rd_acc = 1'b1;
        state_next = S_READ;
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = st.emit_now ? S_DIV : S_STEP;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (st.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (st.tail_more) begin
          cmd.tail_inc = 1'b1;
          state_next   = S_SHIFT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/bmf2d_dp.sv -----
// Datapath of the box mean filter: registers, line store, window, divider.
module bmf2d_dp import bmf2d_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   result
);

  localparam int STORE_ROWS = MAX_KERNEL - 1;
  localparam int KCAP  = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CW1   = CW + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 8);
  localparam int SW    = $clog2(STORE_ROWS);
  localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // config
  logic [3:0]  cfg_kernel;
  logic [10:0] cfg_width;
  logic [10:0] cfg_height;
  logic        restart;

  logic [3:0]    k_odd, k_eff;
  logic [2:0]    h;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] ht_eff;
  logic [7:0]    kk;
  logic [PW-1:0] frame_px;

  // position and work registers
  logic [CW-1:0] ic;
  logic [RW-1:0] ir;
  logic [SW-1:0] cur_slot, rd_slot, rd_prev, cur_inc;
  logic [3:0]    j;
  logic [2:0]    t;
  logic [7:0]    val, val_in;
  logic [11:0]   vsum, shift_val;
  logic [PW-1:0] outpos;
  logic [11:0]   cs [COL_DEPTH];
  logic [15:0]   win, win_new;
  logic [15:0]   rem, dsh;
  logic [7:0]    q;
  logic [2:0]    bitc;
  logic [7:0]    rdata;
  logic [7:0]    mem [DEPTH];

  logic col_last, row_ok, more_after, clear_cols;

  function automatic logic [AW-1:0] line_addr(input logic [SW-1:0] s,
                                              input logic [CW-1:0] c);
    return AW'(s * MAX_WIDTH) + AW'(c);
  endfunction

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL, REG_WIDTH, REG_HEIGHT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_kernel <= 4'd3;
      cfg_width  <= 11'd512;
      cfg_height <= 11'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL: cfg_kernel <= cfg_data[3:0];
        REG_WIDTH:  cfg_width  <= cfg_data;
        REG_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_odd = cfg_kernel | 4'd1;
    k_eff = (int'(k_odd) > KCAP) ? 4'(KCAP) : k_odd;
    h     = k_eff[3:1];
    if (cfg_width == 11'd0) begin
      w_eff = WW'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (cfg_height == 11'd0) begin
      ht_eff = HW'(1);
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      ht_eff = HW'(MAX_HEIGHT);
    end else begin
      ht_eff = HW'(cfg_height);
    end
  end

  always_ff @(posedge clk) begin
    kk       <= 8'(k_eff) * 8'(k_eff);
    frame_px <= PW'(w_eff) * PW'(ht_eff);
  end

  // status
  always_comb begin
    col_last   = (WW'(ic) == w_eff - WW'(1));
    row_ok     = (ir >= RW'(h)) && ((ir - RW'(h)) < RW'(ht_eff));
    more_after = col_last && row_ok && (t < h);
    st.rd_go     = (j <= {h, 1'b0}) && (RW'(j) <= ir);
    st.emit_now  = row_ok && ((CW1'(ic) + CW1'(t)) >= CW1'(h));
    st.div_last  = (bitc == 3'd0);
    st.out_free  = !out_valid || !out_stall;
    st.tail_more = col_last && (t < h);
  end

  always_comb begin
    val_in     = (in_data.operation || (ir >= RW'(ht_eff))) ? 8'd0 : in_data.pixel;
    rd_prev    = (rd_slot == '0) ? SW'(STORE_ROWS - 1) : rd_slot - SW'(1);
    cur_inc    = (cur_slot == SW'(STORE_ROWS - 1)) ? '0 : cur_slot + SW'(1);
    shift_val  = (t == 3'd0) ? vsum : 12'd0;
    clear_cols = (t == 3'd0) && (ic == '0);
    if (clear_cols) begin
      win_new = 16'(shift_val);
    end else begin
      win_new = win + 16'(shift_val) - 16'(cs[k_eff - 4'd1]);
    end
    dsh = 16'(kk) << bitc;
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata <= mem[line_addr(rd_prev, ic)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[line_addr(cur_slot, ic)] <= val;
    end
  end

  // per-item work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val     <= val_in;
      vsum    <= 12'(val_in);
      j       <= 4'd1;
      rd_slot <= cur_slot;
    end
    if (cmd.rd_issue) begin
      rd_slot <= rd_prev;
    end
    if (cmd.rd_acc) begin
      vsum <= vsum + 12'(rdata);
      j    <= j + 4'd1;
    end
    if (cmd.wr) begin
      t <= 3'd0;
    end
    if (cmd.tail_inc) begin
      t <= t + 3'd1;
    end
    if (cmd.shift) begin
      rem  <= win_new;
      q    <= 8'd0;
      bitc <= 3'd7;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem     <= rem - dsh;
        q[bitc] <= 1'b1;
      end
      bitc <= bitc - 3'd1;
    end
  end

  // window of column sums
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win <= '0;
      for (int i = 0; i < COL_DEPTH; i++) begin
        cs[i] <= '0;
      end
    end else if (cmd.shift) begin
      win   <= win_new;
      cs[0] <= shift_val;
      for (int i = 1; i < COL_DEPTH; i++) begin
        cs[i] <= clear_cols ? 12'd0 : cs[i-1];
      end
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ic       <= '0;
      ir       <= '0;
      cur_slot <= '0;
      outpos   <= '0;
    end else begin
      if (cmd.push) begin
        outpos <= outpos + PW'(1);
      end
      if (cmd.advance) begin
        if (col_last) begin
          ic <= '0;
          if (ir + RW'(1) == RW'(ht_eff) + RW'(h)) begin
            ir       <= '0;
            cur_slot <= '0;
            outpos   <= '0;
          end else begin
            ir       <= ir + RW'(1);
            cur_slot <= cur_inc;
          end
        end else begin
          ic <= ic + CW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result.mean_value   <= q;
      result.last_of_run  <= !more_after;
      result.end_of_frame <= (outpos + PW'(1) == frame_px);
    end
  end

endmodule

// ----- rtl/core/box_mean_filter_2d_unit.sv -----
// Top level of the streaming 2-D box mean filter with zero padding.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_stall   | in_data: operation, pixel
//  out      | out_valid / out_stall | result: mean_value, last_of_run,
//           |                       |         end_of_frame
//  cfg      | cfg_we                | cfg_index, cfg_data (no read-back)
//
// One item at a time. An item is worked in the order accept, R line store
// reads (issue, add), write, shift, step, where R = min(row, k-1); a result
// item adds 8 divider steps and an output load after the shift, and each
// zero column past the right edge adds a shift and a step. The single line
// store port and the bit-serial divider set this order.
// Reset (rst, synchronous): kernel 3, 512 x 512, raster position and window
// sums cleared. The line store holds garbage until written.
// A stalled output holds its item; the next item is already accepted then and
// its work waits only when it has a result ready to load.
// A config write to kernel, width or height restarts the frame at row 0, column 0.
`include "box_mean_filter_2d_unit_macros.svh"
module box_mean_filter_2d_unit import bmf2d_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  // sequencer: one state per step of the per-item work
  bmf2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // line store, column-sum window, divider, output register
  bmf2d_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // an accepted item keeps the input closed while it is worked on
  `BMF2D_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // never overwrite an output item still held by a stall
  `BMF2D_ASSERT_IMPL(a_push_needs_room, cmd.push, st.out_free)
  // a loaded result shows up on the output
  `BMF2D_ASSERT_NEXT(a_push_shows, cmd.push, out_valid)
  // the line store is never read and written in the same cycle
  `BMF2D_ASSERT_IMPL(a_port_single, cmd.rd_issue, !cmd.wr)

endmodule
